/* sv/cto_pkg.sv */
// Shared types and constants for the circle/triangle overlap pipeline.
package cto_pkg;

    localparam int NUM_VERTS = 3;

    // Per-item decisions carried past the wide multiply stages.
    typedef struct packed {
        logic                 vertex_hit;
        logic                 center_inside;
        logic [NUM_VERTS-1:0] edge_ok;
    } early_flags_t;

endpackage

/* sv/cto_mul.sv */
// Two-stage unsigned multiplier built from half-width partial products.
module cto_mul #(
    parameter int WIDTH = 34
) (
    input  logic                 clk,
    input  logic [WIDTH-1:0]     a,
    input  logic [WIDTH-1:0]     b,
    output logic [2*WIDTH-1:0]   p
);
    import cto_pkg::*;

    localparam int H  = WIDTH / 2;
    localparam int HW = WIDTH - H;

    logic [2*H-1:0]   ll_reg;
    logic [H+HW-1:0]  lh_reg;
    logic [H+HW-1:0]  hl_reg;
    logic [2*HW-1:0]  hh_reg;
    logic [2*WIDTH-1:0] p_reg;
    logic [2*WIDTH-1:0] p_next;

    always_ff @(posedge clk)
    begin
        ll_reg <= a[H-1:0] * b[H-1:0];
        lh_reg <= a[H-1:0] * b[WIDTH-1:H];
        hl_reg <= a[WIDTH-1:H] * b[H-1:0];
        hh_reg <= a[WIDTH-1:H] * b[WIDTH-1:H];
        p_reg  <= p_next;
    end

    always_comb
    begin
        p_next = ((2*WIDTH)'(hh_reg) << (2*H))
               + (((2*WIDTH)'(lh_reg) + (2*WIDTH)'(hl_reg)) << H)
               + (2*WIDTH)'(ll_reg);
    end

    assign p = p_reg;

endmodule

/* sv/circle_triangle_overlap.sv */
// Top level: pipelined circle/triangle overlap test.
//
// channel   signals                          handshake
// -------   -------------------------------  ------------------------------
// in        start, busy, center/radius/vert  word taken when start && !busy
// out       done, hit                        word valid for one cycle on done
//
// Seven register stages: differences, products, sums, compares, the split wide
// multiply for the edge distance test (partial products, then their sum), final
// compare. One word enters every cycle; its result is on done and hit once it
// leaves the final compare register.
// busy stays low since the receiver cannot stall. Reset clears valid bits only.
module circle_triangle_overlap #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] center_x,
    input  logic signed [COORD_WIDTH-1:0] center_y,
    input  logic        [COORD_WIDTH-1:0] radius,
    input  logic signed [COORD_WIDTH-1:0] vertex0_x,
    input  logic signed [COORD_WIDTH-1:0] vertex0_y,
    input  logic signed [COORD_WIDTH-1:0] vertex1_x,
    input  logic signed [COORD_WIDTH-1:0] vertex1_y,
    input  logic signed [COORD_WIDTH-1:0] vertex2_x,
    input  logic signed [COORD_WIDTH-1:0] vertex2_y,
    output logic                          done,
    output logic                          hit
);
    import cto_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;
    localparam int M  = 2 * W + 2;
    localparam int N  = NUM_VERTS;

    logic [6:0] valid_reg;

    logic signed [W-1:0] vx [N];
    logic signed [W-1:0] vy [N];

    assign vx[0] = vertex0_x;
    assign vy[0] = vertex0_y;
    assign vx[1] = vertex1_x;
    assign vy[1] = vertex1_y;
    assign vx[2] = vertex2_x;
    assign vy[2] = vertex2_y;

    // stage 1
    logic signed [DW-1:0] ap_x_reg [N];
    logic signed [DW-1:0] ap_y_reg [N];
    logic signed [DW-1:0] ab_x_reg [N];
    logic signed [DW-1:0] ab_y_reg [N];
    logic        [W-1:0]  r1_reg;
    // stage 2
    logic signed [PW-1:0] pxx_reg [N];
    logic signed [PW-1:0] pyy_reg [N];
    logic signed [PW-1:0] dxa_reg [N];
    logic signed [PW-1:0] dya_reg [N];
    logic signed [PW-1:0] cxa_reg [N];
    logic signed [PW-1:0] cya_reg [N];
    logic signed [PW-1:0] lxx_reg [N];
    logic signed [PW-1:0] lyy_reg [N];
    logic        [2*W-1:0] r2_reg;
    // stage 3
    logic signed [SW-1:0] d2_reg   [N];
    logic signed [SW-1:0] len2_reg [N];
    logic signed [SW-1:0] dot_reg  [N];
    logic signed [SW-1:0] cr_reg   [N];
    logic        [2*W-1:0] r2b_reg;
    // stage 4
    logic [M-1:0] crmag_reg [N];
    logic [M-1:0] len_m_reg [N];
    logic [M-1:0] r2m_reg;
    early_flags_t flags4_reg;
    early_flags_t flags5_reg;
    early_flags_t flags6_reg;
    early_flags_t flags4_next;

    logic [2*M-1:0] crsq [N];
    logic [2*M-1:0] rlen [N];

    logic hit_reg;
    logic hit_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[5:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        r1_reg  <= radius;
        r2_reg  <= r1_reg * r1_reg;
        r2b_reg <= r2_reg;
        r2m_reg <= M'(r2b_reg);
        for (int i = 0; i < N; i++)
        begin
            ap_x_reg[i] <= DW'(center_x) - DW'(vx[i]);
            ap_y_reg[i] <= DW'(center_y) - DW'(vy[i]);
            ab_x_reg[i] <= DW'(vx[(i + 1) % N]) - DW'(vx[i]);
            ab_y_reg[i] <= DW'(vy[(i + 1) % N]) - DW'(vy[i]);

            pxx_reg[i] <= PW'(ap_x_reg[i] * ap_x_reg[i]);
            pyy_reg[i] <= PW'(ap_y_reg[i] * ap_y_reg[i]);
            dxa_reg[i] <= PW'(ap_x_reg[i] * ab_x_reg[i]);
            dya_reg[i] <= PW'(ap_y_reg[i] * ab_y_reg[i]);
            cxa_reg[i] <= PW'(ab_x_reg[i] * ap_y_reg[i]);
            cya_reg[i] <= PW'(ab_y_reg[i] * ap_x_reg[i]);
            lxx_reg[i] <= PW'(ab_x_reg[i] * ab_x_reg[i]);
            lyy_reg[i] <= PW'(ab_y_reg[i] * ab_y_reg[i]);

            d2_reg[i]   <= SW'(pxx_reg[i]) + SW'(pyy_reg[i]);
            len2_reg[i] <= SW'(lxx_reg[i]) + SW'(lyy_reg[i]);
            dot_reg[i]  <= SW'(dxa_reg[i]) + SW'(dya_reg[i]);
            cr_reg[i]   <= SW'(cxa_reg[i]) - SW'(cya_reg[i]);

            crmag_reg[i] <= cr_reg[i][SW-1] ? M'(-cr_reg[i]) : M'(cr_reg[i]);
            len_m_reg[i] <= M'(len2_reg[i]);
        end
        flags4_reg <= flags4_next;
        flags5_reg <= flags4_reg;
        flags6_reg <= flags5_reg;
        hit_reg    <= hit_next;
    end

    always_comb
    begin
        logic all_pos;
        logic all_neg;
        logic signed [SW-1:0] r2s;
        r2s     = $signed(SW'(r2b_reg));
        all_pos = 1'b1;
        all_neg = 1'b1;
        flags4_next = '0;
        for (int i = 0; i < N; i++)
        begin
            if (d2_reg[i] < r2s)
            begin
                flags4_next.vertex_hit = 1'b1;
            end
            if (!(cr_reg[i] > 0))
            begin
                all_pos = 1'b0;
            end
            if (!(cr_reg[i] < 0))
            begin
                all_neg = 1'b0;
            end
            flags4_next.edge_ok[i] = (len2_reg[i] > 0) && (dot_reg[i] > 0)
                                   && (dot_reg[i] < len2_reg[i]);
        end
        flags4_next.center_inside = all_pos || all_neg;
    end

    for (genvar g = 0; g < N; g++)
    begin : g_edge
        cto_mul #(.WIDTH(M)) u_crsq (
            .clk (clk),
            .a   (crmag_reg[g]),
            .b   (crmag_reg[g]),
            .p   (crsq[g])
        );
        cto_mul #(.WIDTH(M)) u_rlen (
            .clk (clk),
            .a   (r2m_reg),
            .b   (len_m_reg[g]),
            .p   (rlen[g])
        );
    end

    always_comb
    begin
        hit_next = flags6_reg.vertex_hit || flags6_reg.center_inside;
        for (int i = 0; i < N; i++)
        begin
            if (flags6_reg.edge_ok[i] && (crsq[i] < rlen[i]))
            begin
                hit_next = 1'b1;
            end
        end
    end

    assign busy = 1'b0;
    assign done = valid_reg[6];
    assign hit  = hit_reg;

endmodule

/* bench/testbench.sv */
// Self-checking bench for the circle/triangle overlap pipeline.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic signed [CW-1:0] cx, cy;
        logic [CW-1:0] r;
        logic signed [CW-1:0] vx [3];
        logic signed [CW-1:0] vy [3];
    } shape_word_t;

    logic clk, rst_n, start, busy, done, hit;
    logic signed [CW-1:0] center_x, center_y;
    logic [CW-1:0] radius;
    logic signed [CW-1:0] vertex0_x, vertex0_y, vertex1_x, vertex1_y;
    logic signed [CW-1:0] vertex2_x, vertex2_y;

    shape_word_t pending_words[$];
    logic expected_hits[$];
    int send_idle_pct;
    logic hold_for_drain;
    int errors;
    int quiet_cycles;

    circle_triangle_overlap #(.COORD_WIDTH(CW)) u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .center_x(center_x), .center_y(center_y), .radius(radius),
        .vertex0_x(vertex0_x), .vertex0_y(vertex0_y),
        .vertex1_x(vertex1_x), .vertex1_y(vertex1_y),
        .vertex2_x(vertex2_x), .vertex2_y(vertex2_y),
        .done(done), .hit(hit)
    );

    // Exact overlap decision; 130-bit signed math covers every product.
    function automatic logic overlap_of(shape_word_t w);
        logic signed [129:0] apx, apy, abx, aby, len2, dot, cr, r2;
        logic hit_v;
        int pos, neg, n;
        begin
            hit_v = 1'b0;
            pos = 0;
            neg = 0;
            r2 = 130'($signed({1'b0, w.r})) * 130'($signed({1'b0, w.r}));
            for (int i = 0; i < 3; i++) begin
                n = (i == 2) ? 0 : i + 1;
                apx = 130'(w.cx) - 130'(w.vx[i]);
                apy = 130'(w.cy) - 130'(w.vy[i]);
                abx = 130'(w.vx[n]) - 130'(w.vx[i]);
                aby = 130'(w.vy[n]) - 130'(w.vy[i]);
                len2 = abx * abx + aby * aby;
                dot = apx * abx + apy * aby;
                cr = abx * apy - aby * apx;
                if (apx * apx + apy * apy < r2)
                    hit_v = 1'b1;
                if (cr > 0)
                    pos++;
                else if (cr < 0)
                    neg++;
                if (len2 > 0 && dot > 0 && dot < len2 && cr * cr < r2 * len2)
                    hit_v = 1'b1;
            end
            if (pos == 3 || neg == 3)
                hit_v = 1'b1;
            return hit_v;
        end
    endfunction

    function automatic shape_word_t make_word(int cx, int cy, int r, int x0, int y0,
                                              int x1, int y1, int x2, int y2);
        shape_word_t w;
        begin
            w.cx = CW'(cx); w.cy = CW'(cy); w.r = CW'(r);
            w.vx[0] = CW'(x0); w.vy[0] = CW'(y0);
            w.vx[1] = CW'(x1); w.vy[1] = CW'(y1);
            w.vx[2] = CW'(x2); w.vy[2] = CW'(y2);
            return w;
        end
    endfunction

    function automatic logic [CW-1:0] near_coord(int base, int spread);
        return CW'(base + $signed($urandom_range(2 * spread, 0)) - spread);
    endfunction

    function automatic shape_word_t random_word();
        shape_word_t w;
        int mode, base_x, base_y, spread;
        begin
            mode = $urandom_range(9, 0);
            if (mode < 2) begin
                w.cx = CW'($urandom); w.cy = CW'($urandom); w.r = CW'($urandom);
                for (int i = 0; i < 3; i++) begin
                    w.vx[i] = CW'($urandom);
                    w.vy[i] = CW'($urandom);
                end
            end else begin
                // Cluster shapes so hits and misses both occur often.
                spread = (mode < 5) ? 64 : ((mode < 8) ? 2000 : 30000);
                base_x = int'($signed(16'($urandom)));
                base_y = int'($signed(16'($urandom)));
                w.cx = near_coord(base_x, spread);
                w.cy = near_coord(base_y, spread);
                w.r = CW'($urandom_range(spread, 0));
                for (int i = 0; i < 3; i++) begin
                    w.vx[i] = near_coord(base_x, spread);
                    w.vy[i] = near_coord(base_y, spread);
                end
                if (mode == 4)
                    w.vx[2] = CW'(w.vx[0] + (w.vx[1] - w.vx[0]) * 2);
                if (mode == 7) begin
                    w.vx[1] = w.vx[0];
                    w.vy[1] = w.vy[0];
                end
            end
            return w;
        end
    endfunction

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Driver: present the head word, advance on acceptance.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            start <= 1'b0;
            center_x <= '0; center_y <= '0; radius <= '0;
            vertex0_x <= '0; vertex0_y <= '0; vertex1_x <= '0;
            vertex1_y <= '0; vertex2_x <= '0; vertex2_y <= '0;
        end else begin
            if (start && !busy) begin
                expected_hits.push_back(overlap_of(pending_words.pop_front()));
            end
            if (!(start && busy)) begin
                if (pending_words.size() > 0 && !hold_for_drain &&
                    $urandom_range(99, 0) >= send_idle_pct) begin
                    start <= 1'b1;
                    center_x <= pending_words[0].cx;
                    center_y <= pending_words[0].cy;
                    radius <= pending_words[0].r;
                    vertex0_x <= pending_words[0].vx[0];
                    vertex0_y <= pending_words[0].vy[0];
                    vertex1_x <= pending_words[0].vx[1];
                    vertex1_y <= pending_words[0].vy[1];
                    vertex2_x <= pending_words[0].vx[2];
                    vertex2_y <= pending_words[0].vy[2];
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each strobed result against the oldest expectation.
    always @(posedge clk) begin
        if (rst_n) begin
            if (done) begin
                if (expected_hits.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual hit=%b",
                             $time, hit);
                    errors++;
                end else if (expected_hits[0] !== hit) begin
                    $display("%0t: hit mismatch: expected %b, actual %b",
                             $time, expected_hits[0], hit);
                    errors++;
                    void'(expected_hits.pop_front());
                end else begin
                    void'(expected_hits.pop_front());
                end
            end
            if (done || (start && !busy))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("circle_triangle_overlap verification failed");
                $finish;
            end
        end
    end

    initial begin
        errors = 0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        hold_for_drain = 1'b0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, zero radius, center on edge/vertex, degenerate shapes.
        pending_words.push_back(make_word(0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_words.push_back(make_word(0, 0, 1, 0, 0, 0, 0, 0, 0));
        pending_words.push_back(make_word(0, 0, 0, -100, -100, 100, -100, 0, 100));
        pending_words.push_back(make_word(0, 0, 0, -100, -100, 0, 100, 100, -100));
        pending_words.push_back(make_word(0, -100, 1, -100, -100, 100, -100, 0, 100));
        pending_words.push_back(make_word(0, -100, 0, -100, -100, 100, -100, 0, 100));
        pending_words.push_back(make_word(100, -100, 1, -100, -100, 100, -100, 0, 100));
        pending_words.push_back(make_word(0, -110, 10, -100, -100, 100, -100, 0, 100));
        pending_words.push_back(make_word(0, -110, 11, -100, -100, 100, -100, 0, 100));
        pending_words.push_back(make_word(-110, -100, 10, -100, -100, 100, -100, 0, 100));
        pending_words.push_back(make_word(0, 50, 10, -100, 0, 0, 0, 100, 0));
        pending_words.push_back(make_word(0, 5, 10, -100, 0, 0, 0, 100, 0));
        pending_words.push_back(make_word(-32768, -32768, 65535, 32767, 32767,
                                          32767, -32768, -32768, 32767));
        pending_words.push_back(make_word(32767, 32767, 0, -32768, -32768,
                                          -32768, -32768, -32768, -32768));
        pending_words.push_back(make_word(32767, 32767, 65535, -32768, -32768,
                                          -32768, -32768, -32768, -32768));
        pending_words.push_back(make_word(-32768, 32767, 65535, -32768, 32767,
                                          32767, -32768, 0, 0));
        pending_words.push_back(make_word(0, 0, 32768, 32767, 32767, -32768, 32767, 0, 32767));
        pending_words.push_back(make_word(0, 0, 100, 0, 200, 0, 200, 0, 200));

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct = (phase == 1) ? 88 : ((phase == 2) ? 36 : 0);
            for (int k = 0; k < 310; k++)
                pending_words.push_back(random_word());
            wait (pending_words.size() == 0);
            if (phase == 1) begin
                // Pause until the pipeline drains completely.
                hold_for_drain = 1'b1;
                wait (expected_hits.size() == 0);
                @(posedge clk);
                hold_for_drain = 1'b0;
            end
        end
        @(posedge clk);
        wait (expected_hits.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("circle_triangle_overlap verification clean");
        else
            $display("circle_triangle_overlap verification failed");
        $finish;
    end
endmodule

/* circle_triangle_overlap.f */
sv/cto_pkg.sv
sv/cto_mul.sv
sv/circle_triangle_overlap.sv
bench/testbench.sv
